### rtl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and codes of the bisection tile splitter.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int COORD_W = 12;
  localparam int GRAIN_W = 13;
  localparam int SIZE_W  = COORD_W + 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GRAIN_W-1:0] grain_t;
  typedef logic [SIZE_W-1:0]  size_t;

  // operation codes of a request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  localparam grain_t GRAIN_RESET = 13'd64;

  typedef struct packed {
    coord_t x_first;
    coord_t x_final;
    coord_t y_first;
    coord_t y_final;
  } rect_t;

  typedef struct packed {
    logic   operation;
    coord_t region_x_first;
    coord_t region_x_final;
    coord_t region_y_first;
    coord_t region_y_final;
  } in_item_t;

  typedef struct packed {
    logic   tile_valid;
    coord_t tile_x_first;
    coord_t tile_x_final;
    coord_t tile_y_first;
    coord_t tile_y_final;
    logic   last_tile;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_status_t;

  typedef struct packed {
    logic  split;
    rect_t lower;
    rect_t upper;
  } split_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SPLIT
  } state_t;

endpackage

### rtl/bts_split_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_split_unit
// Shared split step: decides whether a rectangle exceeds the grain and
// halves it in x first, else in y.
// ----------------------------------------------------------------------------
module bts_split_unit
  import bts_pkg::*;
(
  input  rect_t      rect,
  input  grain_t     grain,
  output split_res_t res
);

  size_t  x_size;
  size_t  y_size;
  logic   split_x;
  logic   split_y;
  coord_t half;
  coord_t mid;

  assign x_size  = size_t'({1'b0, rect.x_final} - {1'b0, rect.x_first} + 1'b1);
  assign y_size  = size_t'({1'b0, rect.y_final} - {1'b0, rect.y_first} + 1'b1);
  assign split_x = x_size > grain;
  assign split_y = y_size > grain;

  // one halving per step, x wins
  always_comb begin
    res       = '{split: 1'b0, lower: rect, upper: rect};
    half      = '0;
    mid       = '0;
    res.split = split_x | split_y;
    if (split_x) begin
      half            = x_size[SIZE_W-1:1];
      mid             = rect.x_first + half;
      res.upper.x_first = mid;
      res.lower.x_final = mid - 1'b1;
    end else if (split_y) begin
      half            = y_size[SIZE_W-1:1];
      mid             = rect.y_first + half;
      res.upper.y_first = mid;
      res.lower.y_final = mid - 1'b1;
    end
  end

endmodule

### rtl/bts_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_stack
// Stack of pending rectangles in a single-port style memory with a
// registered read and a depth counter.
// ----------------------------------------------------------------------------
module bts_stack
  import bts_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  stk_ctrl_t   ctrl,
  input  rect_t       push_rect,
  output rect_t       rd_rect,
  output stk_status_t status
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = $clog2(STACK_DEPTH);

  rect_t              mem [STACK_DEPTH];
  rect_t              rd_rect_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [DEPTH_W-1:0] depth_dec;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               wr_en;

  assign status.empty = (depth_r == '0);
  assign status.full  = (depth_r == DEPTH_W'(STACK_DEPTH));

  assign depth_dec = depth_r - DEPTH_W'(1);
  assign rd_idx    = depth_dec[IDX_W-1:0];
  assign wr_idx    = ctrl.clear ? '0 : depth_r[IDX_W-1:0];
  // a push onto a full stack is dropped
  assign wr_en     = ctrl.push & (ctrl.clear | ~status.full);

  always_comb begin
    depth_nxt = depth_r;
    priority if (ctrl.clear) begin
      depth_nxt = ctrl.push ? DEPTH_W'(1) : '0;
    end else if (ctrl.pop) begin
      depth_nxt = depth_dec;
    end else if (wr_en) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= push_rect;
    end
    if (ctrl.pop) begin
      rd_rect_r <= mem[rd_idx];
    end
  end

  assign rd_rect = rd_rect_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !status.empty)
    else $error("pop from empty stack");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop && !ctrl.clear |=> depth_r == $past(depth_dec))
    else $error("pop did not drop depth by one");

endmodule

### rtl/bisection_tile_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisection_tile_splitter
// Splits a region into tiles no larger than the grain, one tile per fetch.
// ----------------------------------------------------------------------------
// a load or an exhausted fetch gives its result in the cycle after the request;
//   a fetch pops the stack, reads the rectangle, halves it in the shared split
//   unit until it fits the grain, pushing each upper half, then registers the tile
// throughput: one request at a time, busy stays high during a fetch, also for
//   the stack memory read after the pop
// reset: synchronous, empties the stack and sets the grain to 64; no receiver stalls
module bisection_tile_splitter
  import bts_pkg::*;
#(
  parameter int MAX_DIM     = 4096,
  parameter int STACK_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  grain_t    cfg_data
);

  localparam int GRAIN_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;

  state_t      state_r;
  state_t      state_nxt;
  grain_t      grain_r;
  grain_t      grain_eff;
  rect_t       rect_r;
  rect_t       rect_nxt;
  logic        out_strobe_r;
  logic        out_strobe_nxt;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic        accept;
  stk_ctrl_t   stk_ctrl;
  stk_status_t stk_status;
  rect_t       push_rect;
  rect_t       rd_rect;
  rect_t       region;
  logic        region_ok;
  split_res_t  split_res;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign grain_eff = (grain_r == '0) ? grain_t'(1) :
                     (grain_r > grain_t'(GRAIN_CAP)) ? grain_t'(GRAIN_CAP) : grain_r;

  assign region = '{x_first: in_item.region_x_first, x_final: in_item.region_x_final,
                    y_first: in_item.region_y_first, y_final: in_item.region_y_final};
  assign region_ok = (in_item.region_x_final >= in_item.region_x_first) &&
                     (in_item.region_y_final >= in_item.region_y_first);

  bts_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (stk_ctrl),
    .push_rect(push_rect),
    .rd_rect  (rd_rect),
    .status   (stk_status)
  );

  bts_split_unit u_split (
    .rect (rect_r),
    .grain(grain_eff),
    .res  (split_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.operation == OP_NEXT && !stk_status.empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (!split_res.split) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and stack control
  always_comb begin
    stk_ctrl       = '0;
    push_rect      = split_res.upper;
    rect_nxt       = rect_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == OP_LOAD) begin
            stk_ctrl.clear = 1'b1;
            stk_ctrl.push  = region_ok;
            push_rect      = region;
            out_strobe_nxt = 1'b1;
          end else if (stk_status.empty) begin
            out_strobe_nxt = 1'b1;
          end else begin
            stk_ctrl.pop = 1'b1;
          end
        end
      end
      ST_READ: begin
        rect_nxt = rd_rect;
      end
      ST_SPLIT: begin
        if (split_res.split) begin
          stk_ctrl.push = 1'b1;
          rect_nxt      = split_res.lower;
        end else begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{tile_valid: 1'b1,
                             tile_x_first: rect_r.x_first, tile_x_final: rect_r.x_final,
                             tile_y_first: rect_r.y_first, tile_y_final: rect_r.y_final,
                             last_tile: stk_status.empty};
        end
      end
      default: begin
        stk_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      grain_r      <= GRAIN_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        grain_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rect_r     <= rect_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> state_r == ST_IDLE)
    else $error("result issued while still splitting");

  a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(stk_ctrl.pop))
    else $error("read state without a pop");

  a_last_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_item_r.tile_valid && out_item_r.last_tile |-> stk_status.empty)
    else $error("last tile flagged with rectangles pending");

  a_tile_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_item_r.tile_valid |->
      out_item_r.tile_x_final >= out_item_r.tile_x_first &&
      out_item_r.tile_y_final >= out_item_r.tile_y_first)
    else $error("tile corners inverted");

endmodule
